[hw/rtl/bfh_pkg.sv]
package bfh_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int WIN_DEPTH   = 2 * MAX_WIDTH + 3;
	localparam int ADDR_BITS   = $clog2(WIN_DEPTH);
	localparam int DIM_BITS    = 11;
	localparam int POS_BITS    = 10;
	// frame position runs up to width*height + width
	localparam int CNT_BITS    = 21;
	localparam int Q_BITS      = CNT_BITS + 1;
	localparam int CELL_BITS   = 4;
	localparam int SUM_BITS    = SAMPLE_BITS + CELL_BITS;
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_BITS  = RECIP_SHIFT + 1;
	localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;

	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 11;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_SMOOTH = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] height_sample;
		logic                   pad;
	} in_word_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] filtered_height;
		logic                   last_pixel;
	} out_word_t;

	typedef struct packed {
		logic                 load;
		logic [SUM_BITS-1:0]  sum;
		logic [CELL_BITS-1:0] count;
	} avg_req_t;

	// ceil(2^24 / count); exact quotient for any 20-bit numerator
	function automatic logic [RECIP_BITS-1:0] recip(input logic [CELL_BITS-1:0] count);
		logic [RECIP_BITS-1:0] r;
		case (count)
			4'd1:    r = 25'd16777216;
			4'd2:    r = 25'd8388608;
			4'd3:    r = 25'd5592406;
			4'd4:    r = 25'd4194304;
			4'd5:    r = 25'd3355444;
			4'd6:    r = 25'd2796203;
			4'd7:    r = 25'd2396746;
			4'd8:    r = 25'd2097152;
			4'd9:    r = 25'd1864136;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/box_filter_3x3_heightmap_unit.sv]
// 3x3 box filter over a height map streamed in raster order.
// Input channel (sample_valid / sample_stall / sample): one word per sample;
// a word with pad set carries no sample and only advances the stream.
// Output channel (result_valid / result_stall / result): one filtered word per
// pixel, starting once width+1 words of the frame are in, so results lag the
// input by width+1 words; last_pixel marks the final pixel of the map.
// Config port (cfg_we / cfg_index / cfg_data): width, height, smooth_edges.
// A write to one of these registers restarts the frame; write only while
// the block is idle. A word with no result leaves the unit idle. A filtered
// result holds the input through nine reads on one port, a drain state for
// the last read data, the reciprocal multiply and the load of the output
// register, and result_valid rises with that load. A plain-mode border
// pixel skips the reads and goes straight to the load.
// The result sits in an output register; while result_stall holds it, the
// next word is still accepted and worked on, and the unit waits at the end
// of that word until the register frees up.
// Reset clears the frame counters and loads width=256, height=256, plain mode.
// The window memory is not cleared; only entries written in the frame are read.
module box_filter_3x3_heightmap_unit
	import bfh_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     sample_valid,
	output logic                     sample_stall,
	input  in_word_t                 sample,
	output logic                     result_valid,
	input  logic                     result_stall,
	output out_word_t                result,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [DIM_BITS-1:0]  dim_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;
	typedef logic signed [Q_BITS-1:0] q_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_MUL,
		ST_FINISH
	} state_t;

	localparam logic [ADDR_BITS:0] DEPTH_X = (ADDR_BITS+1)'(WIN_DEPTH);
	localparam addr_t              LAST_ADDR = ADDR_BITS'(WIN_DEPTH - 1);

	function automatic addr_t win_add(input addr_t a, input dim_t b);
		logic [ADDR_BITS:0] s;
		s = {1'b0, a} + (ADDR_BITS+1)'(b);
		if (s >= DEPTH_X) begin
			s = s - DEPTH_X;
		end
		return s[ADDR_BITS-1:0];
	endfunction

	function automatic dim_t clamp_dim(input dim_t d, input dim_t hi);
		dim_t r;
		r = d;
		if (d == '0) begin
			r = dim_t'(1);
		end else if (d > hi) begin
			r = hi;
		end
		return r;
	endfunction

	// configuration
	dim_t w_q, h_q, w_d, h_d;
	logic smooth_q, smooth_d;
	cnt_t bounds_q;
	logic cfg_hit;

	// sequencer
	state_t                 state_q;
	cnt_t                   count_q;
	addr_t                  ptr_q;
	logic [POS_BITS-1:0]    col_q, row_q;
	addr_t                  row_addr_q;
	q_t                     row_pos_q;
	logic [1:0]             cell_row_q, cell_col_q;
	logic                   zero_q, last_q, acc_s1;
	logic [SUM_BITS-1:0]    sum_q;
	logic [CELL_BITS-1:0]   cnt_q;
	logic                   result_valid_q;
	out_word_t              result_q;

	logic                   accept, has_out, col_end, row_end, border;
	logic                   out_load;
	logic [ADDR_BITS:0]     two_w2;
	addr_t                  start_addr, rd_addr, ptr_next;
	q_t                     start_pos, cell_pos;
	logic                   cell_in;
	logic                   wr_en;
	logic [SAMPLE_BITS-1:0] wr_data, rd_data, avg_quot;
	avg_req_t               avg_req;

	always_comb begin
		w_d      = w_q;
		h_d      = h_q;
		smooth_d = smooth_q;
		cfg_hit  = 1'b0;
		if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH: begin
					w_d     = clamp_dim(cfg_data, dim_t'(MAX_WIDTH));
					cfg_hit = 1'b1;
				end
				REG_HEIGHT: begin
					h_d     = clamp_dim(cfg_data, dim_t'(MAX_HEIGHT));
					cfg_hit = 1'b1;
				end
				REG_SMOOTH: begin
					smooth_d = cfg_data[0];
					cfg_hit  = 1'b1;
				end
				default: cfg_hit = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q      <= dim_t'(256);
			h_q      <= dim_t'(256);
			smooth_q <= 1'b0;
			bounds_q <= cnt_t'(65536);
		end else begin
			w_q      <= w_d;
			h_q      <= h_d;
			smooth_q <= smooth_d;
			bounds_q <= cnt_t'(w_d) * cnt_t'(h_d);
		end
	end

	assign sample_stall = (state_q != ST_IDLE);
	assign accept       = sample_valid && !sample_stall;
	assign has_out      = (count_q > cnt_t'(w_q));
	assign col_end      = ({1'b0, col_q} + dim_t'(1)) >= w_q;
	assign row_end      = ({1'b0, row_q} + dim_t'(1)) >= h_q;
	assign border       = (col_q == '0) || (row_q == '0) || col_end || row_end;
	assign out_load     = (state_q == ST_FINISH) && (!result_valid_q || !result_stall);

	// top-left neighbor sits 2*width+2 words behind the newest sample
	assign two_w2    = {w_q, 1'b0} + (ADDR_BITS+1)'(2);
	assign start_pos = q_t'(count_q) - q_t'(two_w2);
	always_comb begin
		if ({1'b0, ptr_q} >= two_w2) begin
			start_addr = ADDR_BITS'({1'b0, ptr_q} - two_w2);
		end else begin
			start_addr = ADDR_BITS'({1'b0, ptr_q} + DEPTH_X - two_w2);
		end
	end

	assign ptr_next = (ptr_q == LAST_ADDR) ? '0 : ptr_q + addr_t'(1);

	assign rd_addr  = win_add(row_addr_q, dim_t'(cell_col_q));
	assign cell_pos = row_pos_q + q_t'(cell_col_q);
	assign cell_in  = !cell_pos[Q_BITS-1] && (cell_pos[CNT_BITS-1:0] < bounds_q);

	assign wr_en   = accept && (count_q < bounds_q);
	assign wr_data = sample.pad ? '0 : sample.height_sample;

	bfh_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (WIN_DEPTH)
	) u_window (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (ptr_q),
		.wr_data (wr_data),
		.rd_en   (state_q == ST_READ),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign avg_req.load  = (state_q == ST_MUL);
	assign avg_req.sum   = sum_q;
	assign avg_req.count = cnt_q;

	bfh_avg u_avg (
		.clk  (clk),
		.req  (avg_req),
		.quot (avg_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			ptr_q          <= '0;
			col_q          <= '0;
			row_q          <= '0;
			row_addr_q     <= '0;
			row_pos_q      <= '0;
			cell_row_q     <= '0;
			cell_col_q     <= '0;
			zero_q         <= 1'b0;
			last_q         <= 1'b0;
			acc_s1         <= 1'b0;
			sum_q          <= '0;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			// read data is registered in the RAM and lands in the cycle after its address
			acc_s1 <= (state_q == ST_READ) && cell_in;
			if (acc_s1) begin
				sum_q <= sum_q + SUM_BITS'(rd_data);
				cnt_q <= cnt_q + CELL_BITS'(1);
			end else if (accept && has_out) begin
				sum_q <= '0;
				cnt_q <= '0;
			end

			if (out_load) begin
				result_valid_q           <= 1'b1;
				result_q.filtered_height <= zero_q ? '0 : avg_quot;
				result_q.last_pixel      <= last_q;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end

			if (cfg_hit) begin
				count_q <= '0;
				ptr_q   <= '0;
				col_q   <= '0;
				row_q   <= '0;
			end else if (accept) begin
				if (has_out && col_end && row_end) begin
					count_q <= '0;
					ptr_q   <= '0;
					col_q   <= '0;
					row_q   <= '0;
				end else begin
					count_q <= count_q + cnt_t'(1);
					ptr_q   <= ptr_next;
					if (has_out) begin
						if (col_end) begin
							col_q <= '0;
							row_q <= row_q + POS_BITS'(1);
						end else begin
							col_q <= col_q + POS_BITS'(1);
						end
					end
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (accept && has_out) begin
						last_q     <= col_end && row_end;
						row_addr_q <= start_addr;
						row_pos_q  <= start_pos;
						cell_row_q <= '0;
						cell_col_q <= '0;
						if (!smooth_q && border) begin
							zero_q  <= 1'b1;
							state_q <= ST_FINISH;
						end else begin
							zero_q  <= 1'b0;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					if (cell_col_q == 2'd2) begin
						cell_col_q <= '0;
						row_addr_q <= win_add(row_addr_q, w_q);
						row_pos_q  <= row_pos_q + q_t'(w_q);
						if (cell_row_q == 2'd2) begin
							state_q <= ST_DRAIN;
						end else begin
							cell_row_q <= cell_row_q + 2'd1;
						end
					end else begin
						cell_col_q <= cell_col_q + 2'd1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[hw/rtl/bfh_ram.sv]
module bfh_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hw/rtl/bfh_avg.sv]
module bfh_avg
	import bfh_pkg::*;
(
	input  logic                   clk,
	input  avg_req_t               req,
	output logic [SAMPLE_BITS-1:0] quot
);

	typedef logic [PROD_BITS-1:0] prod_t;

	logic [SUM_BITS-1:0] num;
	prod_t               prod_q;

	// round half up: (sum + count/2) / count
	assign num = req.sum + SUM_BITS'(req.count >> 1);

	always_ff @(posedge clk) begin
		if (req.load) begin
			prod_q <= prod_t'(num) * prod_t'(recip(req.count));
		end
	end

	assign quot = prod_q[RECIP_SHIFT +: SAMPLE_BITS];

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import bfh_pkg::*;

	localparam logic [CFG_IDX_BITS-1:0] REG_NONE = 2'd3;
	localparam int SETTLE_CYCLES = 20;
	localparam int RANDOM_ITEMS  = 1000;
	localparam int QUIET_ITEMS   = 150;

	logic clk;
	logic arst_n = 1'b0;

	logic                     sample_valid = 1'b0;
	logic                     sample_stall;
	in_word_t                 sample = '0;
	logic                     result_valid;
	logic                     result_stall = 1'b0;
	out_word_t                result;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = REG_WIDTH;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	box_filter_3x3_heightmap_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	in_word_t  pending [$];
	out_word_t due_heights [$];
	int        item_count = 0;
	int        mismatch_count = 0;
	bit        idle_on = 1'b1;
	bit        word_taken = 1'b0;
	int        gap_left = 0;
	int        stall_left = 0;

	// shadow of the filter: window, frame position, registers
	logic [SAMPLE_BITS-1:0]   win_mem [WIN_DEPTH];
	int                       frame_pos = 0;
	int                       out_col = 0;
	int                       out_row = 0;
	logic [CFG_DATA_BITS-1:0] width_reg = 11'd256;
	logic [CFG_DATA_BITS-1:0] height_reg = 11'd256;
	logic                     smooth_reg = 1'b0;

	function automatic int dim_of(logic [CFG_DATA_BITS-1:0] raw, int top);
		if (raw == 0)
			return 1;
		if (raw > top)
			return top;
		return int'(raw);
	endfunction

	function automatic void predict_filtered(in_word_t word);
		int w, h, bounds, pos, q, sum, cnt, dy, dx;
		bit interior;
		out_word_t res;
		w = dim_of(width_reg, MAX_WIDTH);
		h = dim_of(height_reg, MAX_HEIGHT);
		bounds = w * h;
		if (frame_pos < bounds)
			win_mem[frame_pos % WIN_DEPTH] = word.pad ? '0 : word.height_sample;
		frame_pos++;
		// nothing leaves until width+1 words of the frame are in
		if (frame_pos <= w + 1)
			return;
		pos = out_row * w + out_col;
		interior = out_col != 0 && out_row != 0 && out_col + 1 < w && out_row + 1 < h;
		sum = 0;
		cnt = 0;
		// flat-index test only: edge pixels pick up wrapped neighbors
		if (smooth_reg || interior) begin
			for (dy = -1; dy <= 1; dy++) begin
				for (dx = -1; dx <= 1; dx++) begin
					q = pos + dy * w + dx;
					if (q >= 0 && q < bounds) begin
						sum += win_mem[q % WIN_DEPTH];
						cnt++;
					end
				end
			end
		end
		res.filtered_height = (cnt == 0) ? '0 : SAMPLE_BITS'((2 * sum + cnt) / (2 * cnt));
		res.last_pixel = (pos == bounds - 1);
		due_heights = {due_heights, res};
		if (res.last_pixel) begin
			frame_pos = 0;
			out_col = 0;
			out_row = 0;
		end else if (out_col + 1 >= w) begin
			out_col = 0;
			out_row++;
		end else begin
			out_col++;
		end
	endfunction

	always @(posedge clk) begin : monitor
		out_word_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (due_heights.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: result with none expected: height %0d last %0b",
							$time, result.filtered_height, result.last_pixel);
					mismatch_count++;
				end else begin
					want = due_heights.pop_front();
					if (result.filtered_height !== want.filtered_height ||
						result.last_pixel !== want.last_pixel) begin
						if (mismatch_count < 10)
							$display("%0t: expected height %0d last %0b, got height %0d last %0b",
								$time, want.filtered_height, want.last_pixel,
								result.filtered_height, result.last_pixel);
						mismatch_count++;
					end
				end
			end
			if (sample_valid && !sample_stall)
				predict_filtered(sample);
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH:  width_reg = cfg_data;
					REG_HEIGHT: height_reg = cfg_data;
					REG_SMOOTH: smooth_reg = cfg_data[0];
					default: ;
				endcase
				// unknown index leaves the frame alone
				if (cfg_index != REG_NONE) begin
					frame_pos = 0;
					out_col = 0;
					out_row = 0;
				end
			end
		end
		word_taken <= arst_n && sample_valid && !sample_stall;
	end

	always @(negedge clk) begin : drive_samples
		bit hold;
		hold = sample_valid && !word_taken;
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else if (!hold) begin
			if (gap_left == 0 && idle_on && $urandom_range(0, 5) == 0)
				gap_left = $urandom_range(1, 19);
			if (gap_left > 0) begin
				gap_left--;
				sample_valid <= 1'b0;
			end else if (pending.size() != 0) begin
				sample <= pending.pop_front();
				sample_valid <= 1'b1;
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : drive_stall
		if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0)
			stall_left = $urandom_range(1, 19);
		if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_word(logic [SAMPLE_BITS-1:0] height, logic pad);
		pending = {pending, in_word_t'{height_sample: height, pad: pad}};
	endtask

	// one frame plus its flush tail; a partial frame stops at a random word
	task automatic push_frame(int w, int h, bit partial);
		int total, n, i;
		in_word_t word;
		total = w * h + w + 1;
		n = partial ? $urandom_range(0, total - 1) : total;
		for (i = 0; i < n; i++) begin
			case ($urandom_range(0, 7))
				0:       word.height_sample = '0;
				1:       word.height_sample = '1;
				default: word.height_sample = SAMPLE_BITS'($urandom);
			endcase
			word.pad = (i < w * h) ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 3) != 0);
			pending = {pending, word};
		end
		item_count += n;
	endtask

	task automatic drain();
		while (pending.size() != 0 || sample_valid || due_heights.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [CFG_DATA_BITS-1:0] w_raw, h_raw;
		int w, h, kind;
		bit do_w, do_h, do_s;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// 3x3 plain: only the center is filtered, pad inside the frame reads as zero
		write_reg(REG_WIDTH, 11'd3);
		write_reg(REG_HEIGHT, 11'd3);
		write_reg(REG_SMOOTH, 11'd0);
		push_word(16'hFFFF, 1'b0);
		push_word(16'h0000, 1'b0);
		push_word(16'hFFFF, 1'b0);
		push_word(16'h0000, 1'b0);
		push_word(16'hFFFF, 1'b0);
		push_word(16'hFFFF, 1'b1);
		push_word(16'hFFFF, 1'b0);
		push_word(16'hFFFF, 1'b0);
		push_word(16'h0000, 1'b0);
		push_word(16'hFFFF, 1'b1);
		push_word(16'h0000, 1'b1);
		push_word(16'h1234, 1'b0);
		push_word(16'hFFFF, 1'b1);
		drain();

		// zero width and height clamp to a single pixel
		write_reg(REG_WIDTH, 11'd0);
		write_reg(REG_HEIGHT, 11'd0);
		write_reg(REG_SMOOTH, 11'd1);
		push_word(16'hFFFF, 1'b0);
		push_word(16'h0F0F, 1'b0);
		push_word(16'hA5A5, 1'b1);
		drain();

		// 2x2 plain: all border; smooth takes bit 0 only
		write_reg(REG_WIDTH, 11'd2);
		write_reg(REG_HEIGHT, 11'd2);
		write_reg(REG_SMOOTH, 11'h7FE);
		push_word(16'hFFFF, 1'b0);
		push_word(16'h8000, 1'b0);
		push_word(16'h0001, 1'b0);
		push_word(16'h7FFF, 1'b0);
		push_word(16'h0000, 1'b1);
		push_word(16'hFFFF, 1'b1);
		push_word(16'h5555, 1'b0);
		drain();

		item_count = 0;
		w_raw = 11'd2;
		h_raw = 11'd2;
		while (item_count < RANDOM_ITEMS) begin
			idle_on = (item_count < RANDOM_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 4) != 0);
			do_w = $urandom_range(0, 1);
			do_h = $urandom_range(0, 1);
			do_s = $urandom_range(0, 1) || (!do_w && !do_h);
			if ($urandom_range(0, 7) == 0)
				write_reg(REG_NONE, CFG_DATA_BITS'($urandom));
			if (do_w) begin
				w_raw = ($urandom_range(0, 9) == 0) ? 11'd0 : CFG_DATA_BITS'($urandom_range(1, 9));
				write_reg(REG_WIDTH, w_raw);
			end
			if (do_h) begin
				h_raw = ($urandom_range(0, 9) == 0) ? 11'd0 : CFG_DATA_BITS'($urandom_range(1, 7));
				write_reg(REG_HEIGHT, h_raw);
			end
			if (do_s)
				write_reg(REG_SMOOTH, CFG_DATA_BITS'($urandom));
			w = dim_of(w_raw, MAX_WIDTH);
			h = dim_of(h_raw, MAX_HEIGHT);
			kind = $urandom_range(0, 9);
			if (kind == 8) begin
				push_frame(w, h, 1'b1);
			end else begin
				push_frame(w, h, 1'b0);
				if (kind == 6 || kind == 7)
					push_frame(w, h, 1'b0);
				else if (kind == 9)
					push_frame(w, h, 1'b1);
			end
			drain();
		end

		idle_on = 1'b0;
		drain();
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin : watchdog
		#3_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

[files.f]
hw/rtl/bfh_pkg.sv
hw/rtl/bfh_ram.sv
hw/rtl/bfh_avg.sv
hw/rtl/box_filter_3x3_heightmap_unit.sv
test/testbench.sv
